// ===== src/hcc_pkg.sv =====
package hcc_pkg;

    localparam int HourW  = 8;
    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 14;
    localparam int RemW   = 7;
    localparam int CentW  = 8;

    localparam logic [HourW-1:0]  HOURS_PER_DAY_RESET = 8'd24;
    localparam logic [DayW-1:0]   DAY_RESET           = 5'd1;
    localparam logic [MonthW-1:0] MONTH_RESET         = 4'd1;
    localparam logic [YearW-1:0]  YEAR_RESET          = 14'd2000;
    localparam logic [YearW-1:0]  YEAR_LAST           = 14'd9999;
    localparam logic [MonthW:0]   MONTHS_PER_YEAR     = 5'd12;
    localparam logic [RemW-1:0]   REM_LAST            = 7'd99;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [YearW-1:0] CENTURY = 14'd100;

    localparam logic [MonthW-1:0] M_FEB = 4'd2;
    localparam logic [MonthW-1:0] M_APR = 4'd4;
    localparam logic [MonthW-1:0] M_JUN = 4'd6;
    localparam logic [MonthW-1:0] M_SEP = 4'd9;
    localparam logic [MonthW-1:0] M_NOV = 4'd11;

    typedef enum logic {
        KIND_ADVANCE = 1'b0,
        KIND_LOAD    = 1'b1
    } t_kind;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [HourW-1:0]  hour;
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic [CentW-1:0]  cent;
    } t_in_req;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        len = 5'd31;
        unique case (month)
            M_FEB:                      len = leap ? 5'd29 : 5'd28;
            M_APR, M_JUN, M_SEP, M_NOV: len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== src/hourly_calendar_counter_unit.sv =====
// a request is held in the input stage register, then taken into the calendar registers
// throughput: one request per cycle, sustained, with no output stall
// the calendar registers double as the result register; one update per request
// reset (synchronous, active low) gives 00h on 1 january 2000, 24-hour days,
// and empties both the input and the result stage
module hourly_calendar_counter_unit
    import hcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [HourW-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [HourW-1:0]  i_load_hour,
    input  logic [DayW-1:0]   i_load_day,
    input  logic [MonthW-1:0] i_load_month,
    input  logic [YearW-1:0]  i_load_year,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [HourW-1:0]  o_hour,
    output logic [DayW-1:0]   o_day,
    output logic [MonthW-1:0] o_month,
    output logic [YearW-1:0]  o_year
);

    logic [HourW-1:0] r_hours_per_day;
    logic             r_out_valid;
    logic             w_take;
    t_in_req          w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours_per_day <= HOURS_PER_DAY_RESET;
        end else if (i_cfg_we) begin
            r_hours_per_day <= i_cfg_wdata;
        end
    end

    // a held request moves on once the result slot is empty or being read
    assign w_take = w_req.valid && (!r_out_valid || !i_out_stall);

    hcc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_kind  (i_kind),
        .i_hour  (i_load_hour),
        .i_day   (i_load_day),
        .i_month (i_load_month),
        .i_year  (i_load_year),
        .i_take  (w_take),
        .o_stall (o_in_stall),
        .o_req   (w_req)
    );

    hcc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_req           (w_req),
        .i_hours_per_day (r_hours_per_day),
        .o_hour          (o_hour),
        .o_day           (o_day),
        .o_month         (o_month),
        .o_year          (o_year)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_time_holds_without_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable({o_hour, o_day, o_month, o_year}))
        else $error("calendar changed with no request taken");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_req.valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline could move");

    a_hour_below_day_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_req.kind == KIND_ADVANCE)) |=>
            ((o_hour < $past(r_hours_per_day)) || (o_hour == '0)))
        else $error("hour past the day length after an advance");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

// ===== src/hcc_in_stage.sv =====
module hcc_in_stage
    import hcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  logic [HourW-1:0]  i_hour,
    input  logic [DayW-1:0]   i_day,
    input  logic [MonthW-1:0] i_month,
    input  logic [YearW-1:0]  i_year,
    input  logic              i_take,
    output logic              o_stall,
    output t_in_req           o_req
);

    logic              r_valid;
    logic              r_kind;
    logic [HourW-1:0]  r_hour;
    logic [DayW-1:0]   r_day;
    logic [MonthW-1:0] r_month;
    logic [YearW-1:0]  r_year;
    logic [CentW-1:0]  r_cent;
    logic [CentW-1:0]  n_cent;
    logic [YearW+12:0] w_prod;

    // century number of the load year, ahead of the register
    assign w_prod  = 27'(i_year) * 27'(DIV100_MUL);
    assign n_cent  = w_prod[DIV100_SHIFT +: CentW];
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_kind  <= i_kind;
            r_hour  <= i_hour;
            r_day   <= i_day;
            r_month <= i_month;
            r_year  <= i_year;
            r_cent  <= n_cent;
        end
    end

    always_comb begin
        o_req.valid = r_valid;
        o_req.kind  = t_kind'(r_kind);
        o_req.hour  = r_hour;
        o_req.day   = r_day;
        o_req.month = r_month;
        o_req.year  = r_year;
        o_req.cent  = r_cent;
    end

endmodule

// ===== src/hcc_core.sv =====
module hcc_core
    import hcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  t_in_req           i_req,
    input  logic [HourW-1:0]  i_hours_per_day,
    output logic [HourW-1:0]  o_hour,
    output logic [DayW-1:0]   o_day,
    output logic [MonthW-1:0] o_month,
    output logic [YearW-1:0]  o_year
);

    logic [HourW-1:0]  r_hour,  n_hour;
    logic [DayW-1:0]   r_day,   n_day;
    logic [MonthW-1:0] r_month, n_month;
    logic [YearW-1:0]  r_year,  n_year;
    // year mod 100 and low bits of year div 100, kept alongside the year
    logic [RemW-1:0]   r_rem,   n_rem;
    logic [1:0]        r_cent,  n_cent;

    logic [HourW:0]    w_hour_inc;
    logic [DayW:0]     w_day_inc;
    logic [MonthW:0]   w_month_inc;
    logic [YearW-1:0]  w_load_rem;
    logic              w_leap;

    assign w_hour_inc  = {1'b0, r_hour} + 9'd1;
    assign w_day_inc   = {1'b0, r_day} + 6'd1;
    assign w_month_inc = {1'b0, r_month} + 5'd1;
    assign w_load_rem  = i_req.year - (14'(i_req.cent) * CENTURY);
    assign w_leap      = ((r_year[1:0] == 2'd0) && (r_rem != '0)) ||
                         ((r_rem == '0) && (r_cent == 2'd0));

    always_comb begin
        n_hour  = r_hour;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_rem   = r_rem;
        n_cent  = r_cent;
        if (i_req.kind == KIND_LOAD) begin
            n_hour  = i_req.hour;
            n_day   = i_req.day;
            n_month = i_req.month;
            n_year  = i_req.year;
            n_rem   = w_load_rem[RemW-1:0];
            n_cent  = i_req.cent[1:0];
        end else if (w_hour_inc < {1'b0, i_hours_per_day}) begin
            n_hour = w_hour_inc[HourW-1:0];
        end else begin
            n_hour = '0;
            if (w_day_inc <= {1'b0, month_len(r_month, w_leap)}) begin
                n_day = w_day_inc[DayW-1:0];
            end else begin
                n_day = DAY_RESET;
                if (w_month_inc <= MONTHS_PER_YEAR) begin
                    n_month = w_month_inc[MonthW-1:0];
                end else begin
                    n_month = MONTH_RESET;
                    if (r_year >= YEAR_LAST) begin
                        n_year = '0;
                        n_rem  = '0;
                        n_cent = 2'd0;
                    end else begin
                        n_year = r_year + 14'd1;
                        if (r_rem == REM_LAST) begin
                            n_rem  = '0;
                            n_cent = r_cent + 2'd1;
                        end else begin
                            n_rem = r_rem + 7'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour  <= '0;
            r_day   <= DAY_RESET;
            r_month <= MONTH_RESET;
            r_year  <= YEAR_RESET;
            r_rem   <= '0;
            r_cent  <= 2'd0;
        end else if (i_take) begin
            r_hour  <= n_hour;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_rem   <= n_rem;
            r_cent  <= n_cent;
        end
    end

    assign o_hour  = r_hour;
    assign o_day   = r_day;
    assign o_month = r_month;
    assign o_year  = r_year;

endmodule

// ===== verif/hourly_calendar_counter_unit_test.sv =====
`timescale 1ns / 1ps

module hourly_calendar_counter_unit_test;
    import hcc_pkg::*;

    typedef struct packed {
        logic [HourW-1:0]  hour;
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
    } t_calendar;

    typedef struct packed {
        logic             cfg_write;
        logic [HourW-1:0] cfg_value;
        t_kind            kind;
        t_calendar        load;
        logic             typed;
        t_calendar        want;
    } t_script_row;

    localparam t_calendar   NoTime       = '0;
    localparam int          NumRows      = 28;
    localparam int          PhaseCount   = 8;
    localparam int          PhaseItems   = 240;
    localparam int unsigned HoldCycles   = 300;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [HourW-1:0]  i_cfg_wdata  = '0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic              i_kind       = 1'b0;
    logic [HourW-1:0]  i_load_hour  = '0;
    logic [DayW-1:0]   i_load_day   = '0;
    logic [MonthW-1:0] i_load_month = '0;
    logic [YearW-1:0]  i_load_year  = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [HourW-1:0]  o_hour;
    logic [DayW-1:0]   o_day;
    logic [MonthW-1:0] o_month;
    logic [YearW-1:0]  o_year;

    hourly_calendar_counter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_load_hour  (i_load_hour),
        .i_load_day   (i_load_day),
        .i_load_month (i_load_month),
        .i_load_year  (i_load_year),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hour       (o_hour),
        .o_day        (o_day),
        .o_month      (o_month),
        .o_year       (o_year)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // calendar held by the predictor, and its day length
    t_calendar        model_time    = '{8'd0, DAY_RESET, MONTH_RESET, YEAR_RESET};
    logic [HourW-1:0] model_day_len = HOURS_PER_DAY_RESET;
    t_calendar        expected_times [$];

    int          mismatch_count   = 0;
    int          requests_sent    = 0;
    int          loads_sent       = 0;
    int          results_seen     = 0;
    int          settings_written = 0;
    int unsigned send_idle_pct    = 0;
    int unsigned stall_pct        = 0;
    int unsigned holds_asked      = 0;
    int unsigned holds_done       = 0;
    int unsigned hold_left        = 0;

    t_script_row script_rows [NumRows] = '{
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd1,5'd1,4'd1,14'd2000}},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd31,4'd12,14'd9999}, 1'b1,
          '{8'd23,5'd31,4'd12,14'd9999}},
        // end of year 9999 wraps to year 0
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd1,14'd0}},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd28,4'd2,14'd2000}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd29,4'd2,14'd2000}},
        // century that is not a leap year
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd28,4'd2,14'd1900}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd3,14'd1900}},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd28,4'd2,14'd2024}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd28,4'd2,14'd2023}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd30,4'd4,14'd2021}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd5,14'd2021}},
        // every field at its top code, stored unchecked
        '{1'b0, 8'd0, KIND_LOAD, '{8'd255,5'd31,4'd15,14'd16383}, 1'b1,
          '{8'd255,5'd31,4'd15,14'd16383}},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd1,14'd0}},
        '{1'b0, 8'd0, KIND_LOAD, NoTime, 1'b1, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b0, NoTime},
        // day 0 goes to 1 on the carry
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd0,4'd6,14'd5}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd6,14'd5}},
        // month 13 takes 31 days and carries into the year
        '{1'b0, 8'd0, KIND_LOAD, '{8'd23,5'd31,4'd13,14'd7}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd1,14'd8}},
        // zero day length: every advance rolls the day
        '{1'b1, 8'd0, KIND_ADVANCE, NoTime, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd5,5'd10,4'd3,14'd2001}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd11,4'd3,14'd2001}},
        '{1'b1, 8'd255, KIND_ADVANCE, NoTime, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_LOAD, '{8'd254,5'd31,4'd12,14'd9998}, 1'b0, NoTime},
        '{1'b0, 8'd0, KIND_ADVANCE, NoTime, 1'b1, '{8'd0,5'd1,4'd1,14'd9999}},
        '{1'b1, 8'd24, KIND_ADVANCE, NoTime, 1'b0, NoTime}
    };

    function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] month,
                                                      input logic [YearW-1:0] year);
        logic leap;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        case (month)
            M_FEB:                      return leap ? 5'd29 : 5'd28;
            M_APR, M_JUN, M_SEP, M_NOV: return 5'd30;
            default:                    return 5'd31;
        endcase
    endfunction

    function automatic t_calendar advance_hour(input t_calendar now,
                                               input logic [HourW-1:0] day_len);
        t_calendar         nxt;
        logic [HourW:0]    hour_inc;
        logic [DayW:0]     day_inc;
        logic [MonthW:0]   month_inc;
        nxt = now;
        // increments are compared one bit wider, so no wrap hides a carry
        hour_inc = {1'b0, now.hour} + 9'd1;
        if (hour_inc < {1'b0, day_len}) begin
            nxt.hour = hour_inc[HourW-1:0];
            return nxt;
        end
        nxt.hour = '0;
        day_inc = {1'b0, now.day} + 6'd1;
        if (day_inc <= {1'b0, days_in_month(now.month, now.year)}) begin
            nxt.day = day_inc[DayW-1:0];
            return nxt;
        end
        nxt.day = 5'd1;
        month_inc = {1'b0, now.month} + 5'd1;
        if (month_inc <= MONTHS_PER_YEAR) begin
            nxt.month = month_inc[MonthW-1:0];
            return nxt;
        end
        nxt.month = 4'd1;
        nxt.year = (now.year >= YEAR_LAST) ? '0 : now.year + 14'd1;
        return nxt;
    endfunction

    task automatic offer_request(input t_kind kind, input t_calendar load,
                                 input logic typed, input t_calendar want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_load_hour  <= load.hour;
        i_load_day   <= load.day;
        i_load_month <= load.month;
        i_load_year  <= load.year;
        do @(posedge i_clk); while (o_in_stall);
        if (kind == KIND_LOAD) begin
            model_time = load;
            loads_sent++;
        end else begin
            model_time = advance_hour(model_time, model_day_len);
        end
        expected_times.push_back(typed ? want : model_time);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        if (expected_times.size() != 0) begin
            i_in_valid <= 1'b0;
            while (expected_times.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic write_day_length(input logic [HourW-1:0] value);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_day_len = value;
        settings_written++;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: random stall, or a long hold counted here once asked for
    always @(posedge i_clk) begin
        if (holds_done != holds_asked) begin
            hold_left = HoldCycles;
            holds_done++;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_calendar want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_times.size() == 0) begin
                $display("%0t: result %0d %0d/%0d/%0d with nothing expected",
                         $time, o_hour, o_day, o_month, o_year);
                mismatch_count++;
            end else begin
                want = expected_times.pop_front();
                check_field("hour", 32'(want.hour), 32'(o_hour));
                check_field("day", 32'(want.day), 32'(o_day));
                check_field("month", 32'(want.month), 32'(o_month));
                check_field("year", 32'(want.year), 32'(o_year));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_kind            kind;
        t_calendar        load;
        logic [HourW-1:0] phase_day_len [PhaseCount];
        int unsigned      pick;
        phase_day_len = '{8'd24, 8'd1, 8'd255, 8'd0, 8'd7, 8'd24, 8'd12, 8'd255};
        phase_day_len[5] = 8'($urandom_range(2, 254));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[r]) begin
            if (script_rows[r].cfg_write) begin
                write_day_length(script_rows[r].cfg_value);
            end else begin
                offer_request(script_rows[r].kind, script_rows[r].load,
                              script_rows[r].typed, script_rows[r].want);
            end
        end

        for (int phase = 0; phase < PhaseCount; phase++) begin
            write_day_length(phase_day_len[phase]);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 51; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                // long output hold while requests keep coming back to back
                if (phase == 0 && n == PhaseItems / 2) holds_asked++;
                if ($urandom_range(99) == 0) wait_for_results();
                load.hour  = 8'($urandom);
                load.day   = 5'($urandom);
                load.month = 4'($urandom);
                load.year  = 14'($urandom);
                pick = $urandom_range(99);
                if (pick < 72) begin
                    kind = KIND_ADVANCE;
                end else if (pick < 92) begin
                    // valid time just short of an hour, day, month or year carry
                    kind = KIND_LOAD;
                    case ($urandom_range(2))
                        0:       load.month = M_FEB;
                        1:       load.month = 4'd12;
                        default: load.month = 4'($urandom_range(1, 12));
                    endcase
                    case ($urandom_range(3))
                        0:       load.year = 14'(YEAR_LAST - $urandom_range(0, 1));
                        1:       load.year = 14'($urandom_range(0, 99) * 100);
                        default: load.year = 14'($urandom_range(0, 9999));
                    endcase
                    load.day = 5'(days_in_month(load.month, load.year) -
                                  $urandom_range(0, 1));
                    load.hour = (model_day_len > 2) ?
                                8'(model_day_len - 1 - $urandom_range(0, 1)) : '0;
                end else begin
                    kind = KIND_LOAD;
                end
                offer_request(kind, load, 1'b0, NoTime);
            end
        end

        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests (%0d loads), %0d results checked, %0d day lengths",
                 requests_sent, loads_sent, results_seen, settings_written);
        $display("day lengths 0, 1, 24 and 255 with leap and wrap carries, one %0d-cycle hold",
                 HoldCycles);
        if (mismatch_count == 0 && expected_times.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hcc_pkg.sv
src/hcc_in_stage.sv
src/hcc_core.sv
src/hourly_calendar_counter_unit.sv
verif/hourly_calendar_counter_unit_test.sv
